>>> rtl/sfla_pkg.sv
// Package for the sorted free-list allocator: status codes, command codes,
// fit policies and the sequencer state type. No dependencies.
package sfla_pkg;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam int unsigned MIN_TAIL_PAYLOAD = 8;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SHIFTU = 9'b000001000,
        S_WRPICK = 9'b000010000,
        S_FMERGE = 9'b000100000,
        S_SHIFTD = 9'b001000000,
        S_WAIT   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

endpackage

>>> rtl/sfla_table.sv
// Block table memory: one write port and one registered read port.
// Depends on nothing but its parameters.
module sfla_table #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 33
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/sorted_free_list_allocator_core.sv
// Sorted free-list allocator: an address-ordered block table in one memory
// walked by a small sequencer. Depends on sfla_pkg and sfla_table.
// Timing: an allocate scans the table and may shift it up, and a free scans it
// and may shift it down, over N blocks (at most MAX_BLOCKS), one table
// entry being scanned or moved per cycle. One item is in flight at a time.
// Reset clears the sequencer and sets the table to one free block.
module sorted_free_list_allocator_core
    import sfla_pkg::*;
#(
    parameter int unsigned ARENA_BYTES  = 4096,
    parameter int unsigned HEADER_BYTES = 16,
    parameter int unsigned MAX_BLOCKS   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [12:0] request_size,
    input  logic [11:0] data_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [11:0] granted_offset,
    output logic [12:0] granted_size
);

    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned VW = $clog2(ARENA_BYTES + 1);
    localparam int unsigned DW = 2 * VW + 1;
    localparam logic [VW-1:0] HDR  = VW'(HEADER_BYTES);
    localparam logic [VW-1:0] TAIL = VW'(HEADER_BYTES + MIN_TAIL_PAYLOAD);

    typedef struct packed {
        logic [VW-1:0] start;
        logic [VW-1:0] size;
        logic          is_free;
    } blk_t;

    state_t state_reg, state_next;
    logic [1:0] policy_reg;
    logic cmd_reg;
    logic [VW-1:0] want_reg;
    logic [VW-1:0] addr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic found_reg, found_next;
    blk_t pickb_reg, pickb_next;
    blk_t prev_reg, prev_next;
    blk_t carry_reg, carry_next;
    logic [1:0] st_reg, st_next;
    logic [11:0] goff_reg, goff_next;
    logic [12:0] gsz_reg, gsz_next;
    logic init_reg;
    logic rd_pending_reg;
    logic [CW-1:0] rd_idx_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    blk_t          wdata, rblk;
    logic [DW-1:0] rdata;

    sfla_table #(.DEPTH(MAX_BLOCKS), .AW(AW), .DW(DW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rblk = blk_t'(rdata);
    assign cfg_ready = state_reg == S_IDLE;
    assign in_ready  = state_reg == S_IDLE && !init_reg;
    assign out_valid = state_reg == S_OUT;
    assign status = st_reg;
    assign granted_offset = goff_reg;
    assign granted_size = gsz_reg;

    logic rvalid;
    logic better;
    logic rd_req;
    logic [CW-1:0] rd_idx;
    blk_t merged;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pick_next  = pick_reg;
        found_next = found_reg;
        pickb_next = pickb_reg;
        prev_next  = prev_reg;
        carry_next = carry_reg;
        st_next    = st_reg;
        goff_next  = goff_reg;
        gsz_next   = gsz_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        rd_req = 1'b0;
        rd_idx = '0;
        rvalid = rd_pending_reg;
        better = 1'b0;
        merged = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    we = 1'b1;
                    wdata.start = '0;
                    wdata.size = VW'(ARENA_BYTES - HEADER_BYTES);
                    wdata.is_free = 1'b1;
                end
                else if (in_valid)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    pick_next = '0;
                    prev_next = '0;
                    st_next = ST_DONE;
                    goff_next = '0;
                    gsz_next = '0;
                    rd_req = 1'b1;
                    rd_idx = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rvalid)
                begin
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (rblk.is_free && rblk.size >= want_reg)
                        begin
                            better = !found_reg
                                || (policy_reg == FIT_BEST && rblk.size < pickb_reg.size)
                                || (policy_reg == FIT_WORST && rblk.size > pickb_reg.size);
                        end
                        if (better)
                        begin
                            found_next = 1'b1;
                            pick_next = rd_idx_reg;
                            pickb_next = rblk;
                        end
                        if ((better && policy_reg != FIT_BEST && policy_reg != FIT_WORST)
                            || rd_idx_reg + 1'b1 == count_reg)
                        begin
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            rd_req = 1'b1;
                            rd_idx = rd_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (rblk.start + HDR == addr_reg)
                        begin
                            found_next = !rblk.is_free;
                            pick_next = rd_idx_reg;
                            pickb_next = rblk;
                            state_next = S_DECIDE;
                        end
                        else if (rd_idx_reg + 1'b1 == count_reg)
                        begin
                            found_next = 1'b0;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            prev_next = rblk;
                            rd_req = 1'b1;
                            rd_idx = rd_idx_reg + 1'b1;
                        end
                    end
                end
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        st_next = ST_NOFIT;
                        state_next = S_OUT;
                    end
                    else if (count_reg < CW'(MAX_BLOCKS)
                             && pickb_reg.size >= want_reg + TAIL)
                    begin
                        carry_next.start = pickb_reg.start + HDR + want_reg;
                        carry_next.size = pickb_reg.size - want_reg - HDR;
                        carry_next.is_free = 1'b1;
                        pickb_next.size = want_reg;
                        pickb_next.is_free = 1'b0;
                        idx_next = pick_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        rd_req = 1'b1;
                        rd_idx = pick_reg + 1'b1;
                        state_next = S_SHIFTU;
                    end
                    else
                    begin
                        pickb_next.is_free = 1'b0;
                        state_next = S_WRPICK;
                    end
                end
                else if (!found_reg)
                begin
                    st_next = ST_IGNORED;
                    state_next = S_OUT;
                end
                else
                begin
                    pickb_next.is_free = 1'b1;
                    found_next = 1'b0;
                    if (pick_reg + 1'b1 < count_reg)
                    begin
                        rd_req = 1'b1;
                        rd_idx = pick_reg + 1'b1;
                    end
                    state_next = S_FMERGE;
                end
            end
            S_SHIFTU:
            begin
                if (rvalid || idx_reg + 1'b1 == count_reg)
                begin
                    we = 1'b1;
                    waddr = AW'(idx_reg);
                    wdata = carry_reg;
                    carry_next = rblk;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_WRPICK;
                    end
                    else if (idx_reg + 2'd2 < count_reg)
                    begin
                        rd_req = 1'b1;
                        rd_idx = idx_reg + 1'b1;
                    end
                end
            end
            S_WRPICK:
            begin
                we = 1'b1;
                waddr = AW'(pick_reg);
                wdata = pickb_reg;
                goff_next = 12'(pickb_reg.start + HDR);
                gsz_next = 13'(pickb_reg.size);
                st_next = ST_DONE;
                state_next = S_OUT;
            end
            S_FMERGE:
            begin
                if (!rvalid && pick_reg + 1'b1 < count_reg && !found_reg)
                begin
                    merged = pickb_reg;
                end
                else
                begin
                    merged = pickb_reg;
                    idx_next = '0;
                    if (pick_reg + 1'b1 < count_reg && rvalid && rblk.is_free)
                    begin
                        merged.size = pickb_reg.size + HDR + rblk.size;
                        idx_next = pick_reg + 1'b1;
                    end
                    if (pick_reg != '0 && prev_reg.is_free)
                    begin
                        merged.start = prev_reg.start;
                        merged.size = prev_reg.size + HDR + merged.size;
                        we = 1'b1;
                        waddr = AW'(pick_reg - 1'b1);
                        wdata = merged;
                        if (idx_next != '0)
                        begin
                            idx_next = pick_reg + 2'd2;
                            carry_next.start = {{(VW-2){1'b0}}, 2'd2};
                        end
                        else
                        begin
                            idx_next = pick_reg + 1'b1;
                            carry_next.start = {{(VW-1){1'b0}}, 1'b1};
                        end
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = AW'(pick_reg);
                        wdata = merged;
                        if (idx_next != '0)
                        begin
                            idx_next = pick_reg + 2'd2;
                            carry_next.start = {{(VW-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            carry_next.start = '0;
                        end
                    end
                    pickb_next = merged;
                    found_next = 1'b1;
                    if (carry_next.start == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(carry_next.start);
                        if (idx_next < count_reg)
                        begin
                            rd_req = 1'b1;
                            rd_idx = idx_next;
                            state_next = S_SHIFTD;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_SHIFTD:
            begin
                if (rvalid)
                begin
                    we = 1'b1;
                    waddr = AW'(idx_reg - CW'(carry_reg.start));
                    wdata = rblk;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 < count_reg + CW'(carry_reg.start))
                    begin
                        rd_req = 1'b1;
                        rd_idx = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        raddr = AW'(rd_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            policy_reg <= FIT_FIRST;
            count_reg <= CW'(1);
            init_reg <= 1'b1;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            init_reg <= 1'b0;
            rd_pending_reg <= rd_req;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            want_reg <= VW'(request_size);
            addr_reg <= VW'(data_offset);
        end
        rd_idx_reg <= rd_idx;
        idx_reg <= idx_next;
        pick_reg <= pick_next;
        found_reg <= found_next;
        pickb_reg <= pickb_next;
        prev_reg <= prev_next;
        carry_reg <= carry_next;
        st_reg <= st_next;
        goff_reg <= goff_next;
        gsz_reg <= gsz_next;
    end

endmodule

>>> rtl/sfla_checker.sv
// Port-level checker for the allocator core, bound to the top level.
// Depends on sfla_pkg for the status codes.
module sfla_checker
    import sfla_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [11:0] granted_offset,
    input logic [12:0] granted_size
);

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_NOFIT || status == ST_IGNORED))
        else $error("bad status");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> granted_offset == '0 && granted_size == '0)
        else $error("nonzero fields on failure");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped");

endmodule

bind sorted_free_list_allocator_core sfla_checker u_sfla_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_offset(granted_offset), .granted_size(granted_size)
);
